// ===== rtl/ips_pkg.sv =====
// shared types and constants of the image plane scaler
`default_nettype none
package ips_pkg;

	localparam int COORD_W = 12;
	localparam int PIX_W   = 8;
	localparam int FRAC_W  = 8;
	localparam int STEP_W  = 24;
	localparam int SIZE_W  = 9;
	localparam int PROD_W  = COORD_W + STEP_W;
	localparam int IDX_W   = 3;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
	localparam logic [IDX_W-1:0] REG_X_STEP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_Y_STEP     = 3'd4;

	typedef struct packed {
		logic               valid;
		logic               op;
		logic               wr_ok;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic [FRAC_W-1:0]  fx;
		logic [FRAC_W-1:0]  fy;
		logic [PIX_W-1:0]   pix;
	} map_t;

	typedef struct packed {
		logic              valid;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [PIX_W-1:0]  p00;
		logic [PIX_W-1:0]  p01;
		logic [PIX_W-1:0]  p10;
		logic [PIX_W-1:0]  p11;
	} tap_t;

endpackage
`default_nettype wire

// ===== rtl/image_plane_scaler_core.sv =====
// top level of the image plane scaler: registers, mapping, plane memory, blend
//
// usage
//   input channel: an item is taken at a rising edge with start high and busy
//   low. operation 0 stores pixel_in at (row, col) of the plane, operation 1
//   asks for the output pixel at output coordinate (col, row).
//   busy stays low; one item can be taken on every clock.
//   result channel: each compute item gives one pixel_out with result_valid
//   high for one cycle; write items give no result. results leave in item
//   order and are never held.
//   throughput is one item per clock, set by the four plane banks that each
//   serve one neighbour read or one write per cycle.
//   config channel: cfg_index selects mode, src_width, src_height, x_step
//   or y_step; cfg_data is taken when cfg_valid and cfg_ready are high.
//   write only while no item is in flight.
//   reset: registers return to nearest mode, 256 by 256, unit steps; the
//   pipeline empties. plane contents are undefined until written.
`default_nettype none
module image_plane_scaler_core
	import ips_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [PIX_W-1:0]   pixel_in,
	output logic                    result_valid,
	output logic      [PIX_W-1:0]   pixel_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [STEP_W-1:0]  cfg_data
);

	logic              mode_q;
	logic [SIZE_W-1:0] src_width_q, src_height_q;
	logic [STEP_W-1:0] x_step_q, y_step_q;
	map_t              map_s3;
	tap_t              tap_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NEAREST;
			src_width_q  <= SIZE_W'(256);
			src_height_q <= SIZE_W'(256);
			x_step_q     <= STEP_W'(65536);
			y_step_q     <= STEP_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[0];
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SIZE_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SIZE_W-1:0];
				REG_X_STEP:     x_step_q     <= cfg_data;
				REG_Y_STEP:     y_step_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ips_map #(
		.MAX_SRC_WIDTH (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.operation (operation),
		.col       (col),
		.row       (row),
		.pixel_in  (pixel_in),
		.src_width (src_width_q),
		.src_height(src_height_q),
		.x_step    (x_step_q),
		.y_step    (y_step_q),
		.map_s3    (map_s3)
	);

	ips_plane #(
		.MAX_SRC_WIDTH (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
	) u_plane (
		.clk   (clk),
		.arst_n(arst_n),
		.map_s3(map_s3),
		.tap_s4(tap_s4)
	);

	ips_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.tap_s4      (tap_s4),
		.result_valid(result_valid),
		.pixel_out   (pixel_out)
	);

endmodule
`default_nettype wire

// ===== rtl/ips_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module ips_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/ips_map.sv =====
// input register, coordinate multiply and edge clamp stages
`default_nettype none
module ips_map
	import ips_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               operation,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [PIX_W-1:0]   pixel_in,
	input  wire logic [SIZE_W-1:0]  src_width,
	input  wire logic [SIZE_W-1:0]  src_height,
	input  wire logic [STEP_W-1:0]  x_step,
	input  wire logic [STEP_W-1:0]  y_step,
	output map_t                    map_s3
);

	localparam int INT_W = PROD_W - 16;
	localparam logic [COORD_W:0] MAX_W = (COORD_W+1)'(MAX_SRC_WIDTH);
	localparam logic [COORD_W:0] MAX_H = (COORD_W+1)'(MAX_SRC_HEIGHT);

	logic               valid_s1, valid_s2;
	logic               op_s1, op_s2;
	logic [COORD_W-1:0] col_s1, row_s1, col_s2, row_s2;
	logic [PIX_W-1:0]   pix_s1, pix_s2;
	logic [PROD_W-1:0]  px_s2, py_s2;
	map_t               map_d;

	logic [COORD_W:0]   lim_w, lim_h;
	logic [COORD_W-1:0] last_c, last_r, xi, yi;
	logic [INT_W-1:0]   xint, yint;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= operation;
		col_s1 <= col;
		row_s1 <= row;
		pix_s1 <= pixel_in;
		op_s2  <= op_s1;
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		pix_s2 <= pix_s1;
		px_s2  <= {{STEP_W{1'b0}}, col_s1} * {{COORD_W{1'b0}}, x_step};
		py_s2  <= {{STEP_W{1'b0}}, row_s1} * {{COORD_W{1'b0}}, y_step};
	end

	// effective plane size
	always_comb begin
		if (src_width == '0) begin
			lim_w = (COORD_W+1)'(1);
		end else if ((COORD_W+1)'(src_width) > MAX_W) begin
			lim_w = MAX_W;
		end else begin
			lim_w = (COORD_W+1)'(src_width);
		end
		if (src_height == '0) begin
			lim_h = (COORD_W+1)'(1);
		end else if ((COORD_W+1)'(src_height) > MAX_H) begin
			lim_h = MAX_H;
		end else begin
			lim_h = (COORD_W+1)'(src_height);
		end
	end

	assign last_c = COORD_W'(lim_w - (COORD_W+1)'(1));
	assign last_r = COORD_W'(lim_h - (COORD_W+1)'(1));
	assign xint   = px_s2[PROD_W-1:16];
	assign yint   = py_s2[PROD_W-1:16];
	assign xi     = (xint > INT_W'(last_c)) ? last_c : xint[COORD_W-1:0];
	assign yi     = (yint > INT_W'(last_r)) ? last_r : yint[COORD_W-1:0];

	always_comb begin
		map_d.valid = valid_s2;
		map_d.op    = op_s2;
		map_d.wr_ok = ((COORD_W+1)'(col_s2) < MAX_W) && ((COORD_W+1)'(row_s2) < MAX_H);
		map_d.fx    = px_s2[15:8];
		map_d.fy    = py_s2[15:8];
		map_d.pix   = pix_s2;
		if (op_s2 == OP_WRITE) begin
			map_d.x0 = col_s2;
			map_d.y0 = row_s2;
			map_d.x1 = col_s2;
			map_d.y1 = row_s2;
		end else begin
			map_d.x0 = xi;
			map_d.y0 = yi;
			map_d.x1 = (xi < last_c) ? xi + COORD_W'(1) : last_c;
			map_d.y1 = (yi < last_r) ? yi + COORD_W'(1) : last_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_s3 <= '0;
		end else begin
			map_s3 <= map_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ips_plane.sv =====
// four-bank source plane memory, one neighbour per bank per cycle
`default_nettype none
module ips_plane
	import ips_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire map_t map_s3,
	output tap_t      tap_s4
);

	localparam int XAW   = $clog2(MAX_SRC_WIDTH);
	localparam int YAW   = $clog2(MAX_SRC_HEIGHT);
	localparam int BCW   = (XAW > 1) ? XAW - 1 : 1;
	localparam int BRW   = (YAW > 1) ? YAW - 1 : 1;
	localparam int BAW   = BCW + BRW;
	localparam int BDEPTH = 1 << BAW;

	logic [BAW-1:0]     raddr [4];
	logic [PIX_W-1:0]   rdata [4];
	logic [BAW-1:0]     waddr;
	logic [COORD_W-1:0] wxh, wyh;
	logic [1:0]         wbank;
	logic               wr_en;

	logic               valid_s4;
	logic [FRAC_W-1:0]  fx_s4, fy_s4;
	logic               x0p_s4, x1p_s4, y0p_s4, y1p_s4;

	assign wr_en = map_s3.valid && (map_s3.op == OP_WRITE) && map_s3.wr_ok;
	assign wxh   = map_s3.x0 >> 1;
	assign wyh   = map_s3.y0 >> 1;
	assign waddr = {wyh[BRW-1:0], wxh[BCW-1:0]};
	assign wbank = {map_s3.y0[0], map_s3.x0[0]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [COORD_W-1:0] xa, ya, xh, yh;

		assign xa = (map_s3.x0[0] == b[0]) ? map_s3.x0 : map_s3.x1;
		assign ya = (map_s3.y0[0] == b[1]) ? map_s3.y0 : map_s3.y1;
		assign xh = xa >> 1;
		assign yh = ya >> 1;
		assign raddr[b] = {yh[BRW-1:0], xh[BCW-1:0]};

		ips_ram #(
			.WIDTH(PIX_W),
			.DEPTH(BDEPTH)
		) u_ram (
			.clk  (clk),
			.we   (wr_en && (wbank == 2'(b))),
			.waddr(waddr),
			.wdata(map_s3.pix),
			.raddr(raddr[b]),
			.rdata(rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= map_s3.valid && (map_s3.op == OP_COMPUTE);
		end
	end

	always_ff @(posedge clk) begin
		fx_s4  <= map_s3.fx;
		fy_s4  <= map_s3.fy;
		x0p_s4 <= map_s3.x0[0];
		x1p_s4 <= map_s3.x1[0];
		y0p_s4 <= map_s3.y0[0];
		y1p_s4 <= map_s3.y1[0];
	end

	// route bank outputs back to neighbour positions
	always_comb begin
		tap_s4.valid = valid_s4;
		tap_s4.fx    = fx_s4;
		tap_s4.fy    = fy_s4;
		tap_s4.p00   = rdata[{y0p_s4, x0p_s4}];
		tap_s4.p01   = rdata[{y0p_s4, x1p_s4}];
		tap_s4.p10   = rdata[{y1p_s4, x0p_s4}];
		tap_s4.p11   = rdata[{y1p_s4, x1p_s4}];
	end

endmodule
`default_nettype wire

// ===== rtl/ips_blend.sv =====
// horizontal blend stage, vertical blend or nearest pick, and result register
`default_nettype none
module ips_blend
	import ips_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             mode,
	input  wire tap_t             tap_s4,
	output logic                  result_valid,
	output logic      [PIX_W-1:0] pixel_out
);

	localparam int H_W = PIX_W + FRAC_W;
	localparam int V_W = H_W + FRAC_W;

	logic [FRAC_W:0]   wx0, wx1, wy0, wy1;
	logic              valid_s5;
	logic [H_W-1:0]    top_s5, bot_s5;
	logic [FRAC_W-1:0] fy_s5;
	logic [PIX_W-1:0]  p00_s5;
	logic [V_W-1:0]    vsum;
	logic [PIX_W-1:0]  res;

	assign wx1 = {1'b0, tap_s4.fx};
	assign wx0 = (FRAC_W+1)'(1 << FRAC_W) - wx1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s5     <= tap_s4.valid;
			result_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		top_s5 <= H_W'({{(H_W-PIX_W){1'b0}}, tap_s4.p00} * {{(H_W-FRAC_W-1){1'b0}}, wx0})
			+ H_W'({{(H_W-PIX_W){1'b0}}, tap_s4.p01} * {{(H_W-FRAC_W-1){1'b0}}, wx1});
		bot_s5 <= H_W'({{(H_W-PIX_W){1'b0}}, tap_s4.p10} * {{(H_W-FRAC_W-1){1'b0}}, wx0})
			+ H_W'({{(H_W-PIX_W){1'b0}}, tap_s4.p11} * {{(H_W-FRAC_W-1){1'b0}}, wx1});
		fy_s5  <= tap_s4.fy;
		p00_s5 <= tap_s4.p00;
	end

	assign wy1  = {1'b0, fy_s5};
	assign wy0  = (FRAC_W+1)'(1 << FRAC_W) - wy1;
	assign vsum = V_W'({{FRAC_W{1'b0}}, top_s5} * {{(V_W-FRAC_W-1){1'b0}}, wy0})
		+ V_W'({{FRAC_W{1'b0}}, bot_s5} * {{(V_W-FRAC_W-1){1'b0}}, wy1});
	assign res  = (mode == MODE_BILINEAR) ? vsum[V_W-1:H_W] : p00_s5;

	always_ff @(posedge clk) begin
		pixel_out <= res;
	end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for image_plane_scaler_core: directed table and random items checked against a predictor
`timescale 1ns / 1ps
module tb;
	import ips_pkg::*;

	localparam int PLANE_W      = 256;
	localparam int PLANE_H      = 256;
	localparam int ITEM_TARGET  = 770;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PLAN_LEN     = 32;

	localparam logic ROW_ITEM = 1'b0;
	localparam logic ROW_CFG  = 1'b1;

	typedef struct packed {
		logic               is_cfg;
		logic               op;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
		logic [PIX_W-1:0]   pix;
		logic [IDX_W-1:0]   idx;
		logic [STEP_W-1:0]  data;
		logic               typed;
		logic [PIX_W-1:0]   want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic operation;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [PIX_W-1:0] pixel_in;
	logic result_valid;
	logic [PIX_W-1:0] pixel_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [STEP_W-1:0] cfg_data;

	logic              cfg_mode;
	logic [SIZE_W-1:0] cfg_width;
	logic [SIZE_W-1:0] cfg_height;
	logic [STEP_W-1:0] cfg_xstep;
	logic [STEP_W-1:0] cfg_ystep;

	logic [PIX_W-1:0] src_pixels [PLANE_W*PLANE_H];
	bit pixel_loaded [PLANE_W*PLANE_H];
	logic [PIX_W-1:0] pending_pixels [$];

	int items_sent = 0;
	int bad_count = 0;
	int burst_left = 0;
	int cycles = 0;

	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_ITEM, OP_WRITE,   12'd0,    12'd0,    8'd255,  REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd255,  12'd255,  8'd90,   REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd256,  12'd0,    8'h22,   REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd0,    12'd256,  8'h33,   REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd4095, 12'd4095, 8'h11,   REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_COMPUTE, 12'd0,    12'd0,    8'hAB,   REG_MODE, 24'd0, 1'b1, 8'd255},
		'{ROW_ITEM, OP_COMPUTE, 12'd255,  12'd255,  8'd0,    REG_MODE, 24'd0, 1'b1, 8'd90},
		'{ROW_ITEM, OP_COMPUTE, 12'd4095, 12'd4095, 8'd0,    REG_MODE, 24'd0, 1'b1, 8'd90},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_SRC_WIDTH,  24'd0,       1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_SRC_HEIGHT, 24'd0,       1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_X_STEP,     24'hFFFFFF,  1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_Y_STEP,     24'hFFFFFF,  1'b0, 8'd0},
		'{ROW_ITEM, OP_COMPUTE, 12'd4095, 12'd4095, 8'hFF,   REG_MODE, 24'd0, 1'b1, 8'd255},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_SRC_WIDTH,  24'd511,     1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_SRC_HEIGHT, 24'd511,     1'b0, 8'd0},
		'{ROW_ITEM, OP_COMPUTE, 12'd4095, 12'd4095, 8'd0,    REG_MODE, 24'd0, 1'b1, 8'd90},
		'{ROW_ITEM, OP_COMPUTE, 12'd1,    12'd1,    8'd0,    REG_MODE, 24'd0, 1'b1, 8'd90},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_X_STEP,     24'd0,       1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_Y_STEP,     24'd0,       1'b0, 8'd0},
		'{ROW_ITEM, OP_COMPUTE, 12'd4095, 12'd4095, 8'd0,    REG_MODE, 24'd0, 1'b1, 8'd255},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_MODE,       24'd1,       1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_SRC_WIDTH,  24'd2,       1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_SRC_HEIGHT, 24'd2,       1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_X_STEP,     24'h008000,  1'b0, 8'd0},
		'{ROW_CFG,  OP_WRITE,   12'd0, 12'd0, 8'd0, REG_Y_STEP,     24'h008000,  1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd1,    12'd0,    8'd0,    REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd0,    12'd1,    8'd0,    REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_WRITE,   12'd1,    12'd1,    8'd200,  REG_MODE, 24'd0, 1'b0, 8'd0},
		'{ROW_ITEM, OP_COMPUTE, 12'd0,    12'd0,    8'd0,    REG_MODE, 24'd0, 1'b1, 8'd255},
		'{ROW_ITEM, OP_COMPUTE, 12'd1,    12'd1,    8'd0,    REG_MODE, 24'd0, 1'b1, 8'd113},
		'{ROW_ITEM, OP_COMPUTE, 12'd4095, 12'd4095, 8'd0,    REG_MODE, 24'd0, 1'b1, 8'd200},
		'{ROW_ITEM, OP_COMPUTE, 12'd1,    12'd0,    8'd0,    REG_MODE, 24'd0, 1'b1, 8'd127}
	};

	image_plane_scaler_core #(
		.MAX_SRC_WIDTH (PLANE_W),
		.MAX_SRC_HEIGHT(PLANE_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.col         (col),
		.row         (row),
		.pixel_in    (pixel_in),
		.result_valid(result_valid),
		.pixel_out   (pixel_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d pixels pending", pending_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic [PIX_W-1:0] exp_pix;
		if (arst_n && result_valid) begin
			if (pending_pixels.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected pixel_out %0d with nothing pending", pixel_out);
			end else begin
				exp_pix = pending_pixels.pop_front();
				if (pixel_out !== exp_pix) begin
					bad_count++;
					if (bad_count <= 10)
						$display("pixel_out mismatch: expected %0d, got %0d", exp_pix, pixel_out);
				end
			end
		end
	end

	function automatic void map_point(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
			output int unsigned x0, output int unsigned x1, output int unsigned y0,
			output int unsigned y1, output int unsigned fx, output int unsigned fy);
		int unsigned last_c, last_r;
		logic [PROD_W-1:0] px, py;
		last_c = (cfg_width == 0) ? 0 : ((cfg_width > PLANE_W) ? PLANE_W - 1 : cfg_width - 1);
		last_r = (cfg_height == 0) ? 0 : ((cfg_height > PLANE_H) ? PLANE_H - 1 : cfg_height - 1);
		px = c * cfg_xstep;
		py = r * cfg_ystep;
		x0 = (px[PROD_W-1:16] > last_c) ? last_c : px[PROD_W-1:16];
		y0 = (py[PROD_W-1:16] > last_r) ? last_r : py[PROD_W-1:16];
		x1 = (x0 < last_c) ? x0 + 1 : last_c;
		y1 = (y0 < last_r) ? y0 + 1 : last_r;
		fx = px[15:8];
		fy = py[15:8];
	endfunction

	function automatic logic [PIX_W-1:0] scaled_pixel(input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] r);
		int unsigned x0, x1, y0, y1, fx, fy, upper, lower;
		map_point(c, r, x0, x1, y0, y1, fx, fy);
		if (cfg_mode == MODE_NEAREST)
			return src_pixels[y0*PLANE_W + x0];
		upper = src_pixels[y0*PLANE_W + x0] * (256 - fx) + src_pixels[y0*PLANE_W + x1] * fx;
		lower = src_pixels[y1*PLANE_W + x0] * (256 - fx) + src_pixels[y1*PLANE_W + x1] * fx;
		return PIX_W'((upper * (256 - fy) + lower * fy) >> 16);
	endfunction

	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	task automatic send_item(input logic op, input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] r, input logic [PIX_W-1:0] pix,
			input logic typed, input logic [PIX_W-1:0] want);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		col <= c;
		row <= r;
		pixel_in <= pix;
		do @(posedge clk); while (busy);
		if (op == OP_WRITE) begin
			if (c < PLANE_W && r < PLANE_H) begin
				src_pixels[r*PLANE_W + c] = pix;
				pixel_loaded[r*PLANE_W + c] = 1'b1;
				items_sent++;
			end
		end else begin
			pending_pixels.push_back(typed ? want : scaled_pixel(c, r));
			items_sent++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:       cfg_mode = data[0];
			REG_SRC_WIDTH:  cfg_width = data[SIZE_W-1:0];
			REG_SRC_HEIGHT: cfg_height = data[SIZE_W-1:0];
			REG_X_STEP:     cfg_xstep = data;
			REG_Y_STEP:     cfg_ystep = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_taps(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
		int unsigned x0, x1, y0, y1, fx, fy;
		int unsigned xs [4];
		int unsigned ys [4];
		map_point(c, r, x0, x1, y0, y1, fx, fy);
		xs = '{x0, x1, x0, x1};
		ys = '{y0, y0, y1, y1};
		for (int k = 0; k < 4; k++)
			if (!pixel_loaded[ys[k]*PLANE_W + xs[k]])
				send_item(OP_WRITE, COORD_W'(xs[k]), COORD_W'(ys[k]),
					PIX_W'($urandom_range(0, 255)), 1'b0, 8'd0);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 7))
			0: return 9'd1;
			1: return 9'd256;
			2: return 9'd0;
			3: return 9'd511;
			4: return 9'd2;
			default: return SIZE_W'($urandom_range(1, 256));
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'h010000;
			3: return STEP_W'($urandom_range(0, 24'hFFFFFF));
			default: return STEP_W'($urandom_range(24'h000100, 24'h040000));
		endcase
	endfunction

	function automatic int unsigned coord_span(input logic [SIZE_W-1:0] size,
			input logic [STEP_W-1:0] step);
		int unsigned span;
		if (step == 0)
			return 4095;
		span = ((int'(size) + 2) << 16) / step;
		return (span > 4095) ? 4095 : span;
	endfunction

	initial begin
		int phase_end;
		int unsigned span_c, span_r;
		logic [COORD_W-1:0] c, r;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_WRITE;
		col = '0;
		row = '0;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		cfg_mode = MODE_NEAREST;
		cfg_width = 9'd256;
		cfg_height = 9'd256;
		cfg_xstep = 24'h010000;
		cfg_ystep = 24'h010000;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg == ROW_CFG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_item(plan[i].op, plan[i].c, plan[i].r, plan[i].pix,
					plan[i].typed, plan[i].want);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			write_reg(REG_MODE, STEP_W'($urandom_range(0, 1)));
			write_reg(REG_SRC_WIDTH, STEP_W'(pick_size()));
			write_reg(REG_SRC_HEIGHT, STEP_W'(pick_size()));
			write_reg(REG_X_STEP, pick_step());
			write_reg(REG_Y_STEP, pick_step());
			span_c = coord_span(cfg_width, cfg_xstep);
			span_r = coord_span(cfg_height, cfg_ystep);
			phase_end = items_sent + $urandom_range(40, 140);
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				if ($urandom_range(0, 99) == 0)
					wait_idle();
				if ($urandom_range(0, 4) == 0) begin
					c = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom_range(0, 4095))
						: COORD_W'($urandom_range(0, PLANE_W - 1));
					r = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom_range(0, 4095))
						: COORD_W'($urandom_range(0, PLANE_H - 1));
					send_item(OP_WRITE, c, r, PIX_W'($urandom_range(0, 255)), 1'b0, 8'd0);
				end else begin
					c = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 4095))
						: COORD_W'($urandom_range(0, span_c));
					r = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 4095))
						: COORD_W'($urandom_range(0, span_r));
					load_taps(c, r);
					send_item(OP_COMPUTE, c, r, PIX_W'($urandom_range(0, 255)), 1'b0, 8'd0);
				end
			end
		end

		wait_idle();
		if (bad_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ips_pkg.sv
rtl/ips_ram.sv
rtl/ips_map.sv
rtl/ips_plane.sv
rtl/ips_blend.sv
rtl/image_plane_scaler_core.sv
test/tb.sv
